>>> design/srtf_pkg.sv
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared constants and action codes of the shortest-remaining-time scheduler.
// ----------------------------------------------------------------------------
package srtf_pkg;

	// default sizing of the job table and the time base
	localparam int MAX_JOBS_DEF  = 16;
	localparam int TIME_BITS_DEF = 16;

	// fixed widths of the channel fields
	localparam int ACTION_W   = 2;
	localparam int IN_TIME_W  = 16;
	localparam int OUT_TIME_W = 16;
	localparam int JOB_ID_W   = 5;

	// action codes of a command item
	localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

endpackage

>>> design/srtf_cmd_if.sv
// ----------------------------------------------------------------------------
// srtf_cmd_if
// Command channel: one item loads a job, ticks time or clears the table.
// ----------------------------------------------------------------------------
interface srtf_cmd_if;

	logic                             valid;
	logic                             ready;
	logic [srtf_pkg::ACTION_W-1:0]    action;
	logic [srtf_pkg::IN_TIME_W-1:0]   arrive_at;
	logic [srtf_pkg::IN_TIME_W-1:0]   work_len;

	modport source (
		output valid,
		output action,
		output arrive_at,
		output work_len,
		input  ready
	);

	modport sink (
		input  valid,
		input  action,
		input  arrive_at,
		input  work_len,
		output ready
	);

endinterface

>>> design/srtf_rsp_if.sv
// ----------------------------------------------------------------------------
// srtf_rsp_if
// Result channel: one item per command item.
// ----------------------------------------------------------------------------
interface srtf_rsp_if;

	logic                             valid;
	logic                             ready;
	logic                             load_refused;
	logic                             ran_job;
	logic [srtf_pkg::JOB_ID_W-1:0]    job_id;
	logic                             job_finished;
	logic [srtf_pkg::OUT_TIME_W-1:0]  turnaround;
	logic [srtf_pkg::OUT_TIME_W-1:0]  waiting;
	logic [srtf_pkg::OUT_TIME_W-1:0]  time_now;
	logic                             all_done;

	modport source (
		output valid,
		output load_refused,
		output ran_job,
		output job_id,
		output job_finished,
		output turnaround,
		output waiting,
		output time_now,
		output all_done,
		input  ready
	);

	modport sink (
		input  valid,
		input  load_refused,
		input  ran_job,
		input  job_id,
		input  job_finished,
		input  turnaround,
		input  waiting,
		input  time_now,
		input  all_done,
		output ready
	);

endinterface

>>> design/srtf_ram.sv
// ----------------------------------------------------------------------------
// srtf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module srtf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write, then register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> design/srtf_sel.sv
// ----------------------------------------------------------------------------
// srtf_sel
// Running selector: compares one table entry per cycle against the best so far.
// ----------------------------------------------------------------------------
module srtf_sel #(
	parameter int IDX_W     = 4,
	parameter int TIME_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clr,
	input  logic                 vld,
	input  logic [IDX_W-1:0]     idx,
	input  logic [TIME_BITS-1:0] arr,
	input  logic [TIME_BITS-1:0] bur,
	input  logic [TIME_BITS-1:0] rem,
	input  logic [TIME_BITS-1:0] time_now,
	output logic                 found,
	output logic [IDX_W-1:0]     best_idx,
	output logic [TIME_BITS-1:0] best_arr,
	output logic [TIME_BITS-1:0] best_bur,
	output logic [TIME_BITS-1:0] best_rem
);

	logic                 found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [TIME_BITS-1:0] best_arr_q;
	logic [TIME_BITS-1:0] best_bur_q;
	logic [TIME_BITS-1:0] best_rem_q;
	logic                 eligible;
	logic                 take;

	// eligible: arrived, work left; ties go to earlier arrival, then earlier load
	assign eligible = (rem != '0) && (arr <= time_now);
	assign take     = vld && eligible &&
	                  (!found_q || (rem < best_rem_q) ||
	                   ((rem == best_rem_q) && (arr < best_arr_q)));

	// hold the best candidate, restart on clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= 1'b0;
			best_idx_q <= '0;
			best_arr_q <= '0;
			best_bur_q <= '0;
			best_rem_q <= '0;
		end else if (clr) begin
			found_q <= 1'b0;
		end else if (take) begin
			found_q    <= 1'b1;
			best_idx_q <= idx;
			best_arr_q <= arr;
			best_bur_q <= bur;
			best_rem_q <= rem;
		end
	end

	assign found    = found_q;
	assign best_idx = best_idx_q;
	assign best_arr = best_arr_q;
	assign best_bur = best_bur_q;
	assign best_rem = best_rem_q;

	// a candidate is only dropped by a clear
	a_found_holds: assert property (@(posedge clk) disable iff (!arst_n)
		found_q && !clr |=> found_q)
		else $error("selector lost its candidate without a clear");

	// a chosen job always has work left
	a_best_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (best_rem_q != '0))
		else $error("selector holds a job with no work left");

	// a clear drops any candidate
	a_clear_drops: assert property (@(posedge clk) disable iff (!arst_n)
		clr |=> !found_q)
		else $error("selector kept a candidate across a clear");

endmodule

>>> design/srtf_scheduler.sv
// ----------------------------------------------------------------------------
// srtf_scheduler
// Shortest-remaining-time-first scheduler over a job table held in one RAM.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake    | payload
//  --------+-----+--------------+------------------------------------------
//  cmd     | in  | valid/ready  | action, arrive_at, work_len
//  rsp     | out | valid/ready  | load_refused, ran_job, job_id, job_finished,
//          |     |              | turnaround, waiting, time_now, all_done
//
//  Load, clear, unused actions and a tick on an empty table go straight to emit.
//  A tick on a filled table scans the table: the job RAM has one read
//  port, so the scan reads one entry per cycle, then the read drains, the
//  chosen job is written back and the output register is loaded.
//  One item is in work at a time; a result waits in the output register while
//  the next item is taken, and the block stalls only when that register is full.
//  Reset clears counters and time; the job RAM needs no clearing pass.
//
module srtf_scheduler #(
	parameter int MAX_JOBS  = srtf_pkg::MAX_JOBS_DEF,
	parameter int TIME_BITS = srtf_pkg::TIME_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	srtf_cmd_if.sink    cmd,
	srtf_rsp_if.source  rsp
);

	localparam int IDX_W   = $clog2(MAX_JOBS);
	localparam int CNT_W   = $clog2(MAX_JOBS + 1);
	localparam int ENTRY_W = 3 * TIME_BITS;
	localparam int ID_W    = srtf_pkg::JOB_ID_W;
	localparam int OUT_W   = srtf_pkg::OUT_TIME_W;
	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(MAX_JOBS);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_UPDATE, ST_EMIT} state_t;

	typedef struct packed {
		logic             load_refused;
		logic             ran_job;
		logic [ID_W-1:0]  job_id;
		logic             job_finished;
		logic [OUT_W-1:0] turnaround;
		logic [OUT_W-1:0] waiting;
	} item_res_t;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     active_q;
	logic [TIME_BITS-1:0] time_q;
	logic [CNT_W-1:0]     scan_idx_q;
	logic                 rd_vld_s1;
	logic [IDX_W-1:0]     scan_idx_s1;
	item_res_t            res_q;
	item_res_t            out_q;
	logic [OUT_W-1:0]     out_time_q;
	logic                 out_done_q;
	logic                 out_valid_q;

	logic                 cmd_take;
	logic                 emit_now;
	logic                 table_full;
	logic                 scan_issue;
	logic [31:0]          arr_in32;
	logic [31:0]          bur_in32;
	logic [TIME_BITS-1:0] arr_in;
	logic [TIME_BITS-1:0] bur_in;
	item_res_t            ld_res;
	item_res_t            upd_res;

	logic                 wr_en;
	logic                 load_wr;
	logic                 upd_wr;
	logic [IDX_W-1:0]     wr_addr;
	logic [ENTRY_W-1:0]   wr_data;
	logic [ENTRY_W-1:0]   rd_data;

	logic                 sel_found;
	logic [IDX_W-1:0]     sel_idx;
	logic [TIME_BITS-1:0] sel_arr;
	logic [TIME_BITS-1:0] sel_bur;
	logic [TIME_BITS-1:0] sel_rem;

	logic [TIME_BITS-1:0] time_inc;
	logic [TIME_BITS-1:0] upd_rem;
	logic [TIME_BITS-1:0] upd_tat;
	logic [TIME_BITS-1:0] upd_wt;
	logic [31:0]          ld_id32;
	logic [31:0]          upd_id32;
	logic [31:0]          time32;
	logic [31:0]          tat32;
	logic [31:0]          wt32;

	// take a command only between items
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_take  = cmd.valid && cmd.ready;

	// load the output register once it is empty or being drained
	assign emit_now = (state_q == ST_EMIT) && (!out_valid_q || rsp.ready);

	// fit the input times to the internal time base
	assign arr_in32 = 32'(cmd.arrive_at);
	assign bur_in32 = 32'(cmd.work_len);
	assign arr_in   = arr_in32[TIME_BITS-1:0];
	assign bur_in   = bur_in32[TIME_BITS-1:0];

	assign table_full = (count_q >= FULL_COUNT);
	assign scan_issue = (state_q == ST_SCAN) && (scan_idx_q < count_q);

	// update arithmetic for the chosen job
	assign time_inc = time_q + TIME_BITS'(1);
	assign upd_rem  = sel_rem - TIME_BITS'(1);
	assign upd_tat  = time_inc - sel_arr;
	assign upd_wt   = upd_tat - sel_bur;
	assign ld_id32  = 32'(count_q) + 32'd1;
	assign upd_id32 = 32'(sel_idx) + 32'd1;
	assign time32   = 32'(time_q);
	assign tat32    = 32'(upd_tat);
	assign wt32     = 32'(upd_wt);

	// result fields of a command that finishes at accept
	always_comb begin
		ld_res = '0;
		if (cmd.action == srtf_pkg::ACT_LOAD) begin
			if (table_full) begin
				ld_res.load_refused = 1'b1;
			end else begin
				ld_res.job_id = ld_id32[ID_W-1:0];
			end
		end
	end

	// result fields of a tick after the scan
	always_comb begin
		upd_res = '0;
		if (sel_found) begin
			upd_res.ran_job = 1'b1;
			upd_res.job_id  = upd_id32[ID_W-1:0];
			if (upd_rem == '0) begin
				upd_res.job_finished = 1'b1;
				upd_res.turnaround   = tat32[OUT_W-1:0];
				upd_res.waiting      = wt32[OUT_W-1:0];
			end
		end
	end

	// write port: append on load, write back remaining work after a tick
	assign load_wr = cmd_take && (cmd.action == srtf_pkg::ACT_LOAD) && !table_full;
	assign upd_wr  = (state_q == ST_UPDATE) && sel_found;
	assign wr_en   = load_wr || upd_wr;
	assign wr_addr = upd_wr ? sel_idx : count_q[IDX_W-1:0];
	assign wr_data = upd_wr ? {sel_arr, sel_bur, upd_rem} : {arr_in, bur_in, bur_in};

	srtf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_JOBS)
	) u_job_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (scan_idx_q[IDX_W-1:0]),
		.rdata (rd_data)
	);

	srtf_sel #(
		.IDX_W     (IDX_W),
		.TIME_BITS (TIME_BITS)
	) u_sel (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (cmd_take),
		.vld      (rd_vld_s1),
		.idx      (scan_idx_s1),
		.arr      (rd_data[3*TIME_BITS-1:2*TIME_BITS]),
		.bur      (rd_data[2*TIME_BITS-1:TIME_BITS]),
		.rem      (rd_data[TIME_BITS-1:0]),
		.time_now (time_q),
		.found    (sel_found),
		.best_idx (sel_idx),
		.best_arr (sel_arr),
		.best_bur (sel_bur),
		.best_rem (sel_rem)
	);

	// index of the word now on the RAM read port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_s1 <= '0;
		end else begin
			scan_idx_s1 <= scan_idx_q[IDX_W-1:0];
		end
	end

	// sequencer: decode, scan, write back, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			active_q    <= '0;
			time_q      <= '0;
			scan_idx_q  <= '0;
			rd_vld_s1   <= 1'b0;
			res_q       <= '0;
			out_q       <= '0;
			out_time_q  <= '0;
			out_done_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= scan_issue;
			if (emit_now) begin
				out_valid_q <= 1'b1;
			end else if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						res_q <= ld_res;
						case (cmd.action)
							srtf_pkg::ACT_LOAD: begin
								state_q <= ST_EMIT;
								if (!table_full) begin
									count_q <= count_q + CNT_W'(1);
									if (bur_in != '0) begin
										active_q <= active_q + CNT_W'(1);
									end
								end
							end
							srtf_pkg::ACT_TICK: begin
								if (count_q == '0) begin
									time_q  <= time_inc;
									state_q <= ST_EMIT;
								end else begin
									scan_idx_q <= '0;
									state_q    <= ST_SCAN;
								end
							end
							srtf_pkg::ACT_CLEAR: begin
								count_q  <= '0;
								active_q <= '0;
								time_q   <= '0;
								state_q  <= ST_EMIT;
							end
							default: begin
								state_q <= ST_EMIT;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_issue) begin
						scan_idx_q <= scan_idx_q + CNT_W'(1);
					end else if (!rd_vld_s1) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					time_q  <= time_inc;
					res_q   <= upd_res;
					state_q <= ST_EMIT;
					if (sel_found && (upd_rem == '0)) begin
						active_q <= active_q - CNT_W'(1);
					end
				end
				ST_EMIT: begin
					if (emit_now) begin
						out_q      <= res_q;
						out_time_q <= time32[OUT_W-1:0];
						out_done_q <= (active_q == '0);
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// drive the result channel from the output register
	assign rsp.valid        = out_valid_q;
	assign rsp.load_refused = out_q.load_refused;
	assign rsp.ran_job      = out_q.ran_job;
	assign rsp.job_id       = out_q.job_id;
	assign rsp.job_finished = out_q.job_finished;
	assign rsp.turnaround   = out_q.turnaround;
	assign rsp.waiting      = out_q.waiting;
	assign rsp.time_now     = out_time_q;
	assign rsp.all_done     = out_done_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_COUNT)
		else $error("job count beyond table depth");

	a_active_bound: assert property (@(posedge clk) disable iff (!arst_n)
		active_q <= count_q)
		else $error("more unfinished jobs than loaded jobs");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !wr_en)
		else $error("job RAM written during a scan");

endmodule

>>> verif/srtf_scheduler_tb.sv
// ----------------------------------------------------------------------------
// srtf_scheduler_tb
// Self-checking bench for the shortest-remaining-time-first scheduler.
// A short directed table, then random job sets: clear, a batch of loads,
// ticks until the table drains.
// A behavioral predictor works out each result at command accept; the
// response monitor compares every result item, field by field, in order.
// ----------------------------------------------------------------------------
module srtf_scheduler_tb;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int AW           = srtf_pkg::ACTION_W;
	localparam int IW           = srtf_pkg::IN_TIME_W;
	localparam int OW           = srtf_pkg::OUT_TIME_W;
	localparam int IDW          = srtf_pkg::JOB_ID_W;
	localparam int JOBS         = srtf_pkg::MAX_JOBS_DEF;
	localparam int TW           = srtf_pkg::TIME_BITS_DEF;
	localparam int LIMIT_CYCLES = 500_000;
	localparam int DRAIN_CYCLES = 2 * (JOBS + 4) + 8;
	localparam int RANDOM_ITEMS = 1120;
	localparam int QUIET_FROM   = 980;
	localparam int HOLD_CYCLES  = 400;
	localparam int MAX_REPORTS  = 100;

	// action code the block leaves unused
	localparam logic [AW-1:0] ACT_UNUSED = 2'd3;

	typedef struct packed {
		logic           load_refused;
		logic           ran_job;
		logic [IDW-1:0] job_id;
		logic           job_finished;
		logic [OW-1:0]  turnaround;
		logic [OW-1:0]  waiting;
		logic [OW-1:0]  time_now;
		logic           all_done;
	} sched_rsp_t;

	typedef struct {
		logic [AW-1:0] action;
		logic [IW-1:0] arrival;
		logic [IW-1:0] burst;
		bit            fixed;
		sched_rsp_t    want;
	} dir_row_t;

	logic clk;
	logic arst_n;

	srtf_cmd_if cmd_ch ();
	srtf_rsp_if rsp_ch ();

	srtf_scheduler u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch)
	);

	// shadow job table and clock of the scheduler
	logic [TW-1:0] job_arrival [JOBS];
	logic [TW-1:0] job_burst   [JOBS];
	logic [TW-1:0] job_left    [JOBS];
	int unsigned   job_total;
	logic [TW-1:0] sched_time;

	sched_rsp_t  pending_results [$];
	int unsigned fail_count;
	int unsigned items_sent;
	int unsigned results_checked;
	int unsigned jobs_finished;
	int unsigned random_sets;
	bit          quiet;
	bit          hold_req;

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// true when every loaded job has no work left
	function automatic bit table_drained();
		for (int k = 0; k < job_total; k++) begin
			if (job_left[k] != '0)
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// work out the result of one command and advance the shadow state
	function automatic sched_rsp_t srtf_next_result(input logic [AW-1:0] action,
			input logic [IW-1:0] arrival, input logic [IW-1:0] burst);
		sched_rsp_t  r;
		bit          found;
		int unsigned best;
		int unsigned id_val;
		logic [TW-1:0] tat;
		r = '0;
		found = 1'b0;
		best = 0;
		id_val = 0;
		case (action)
		srtf_pkg::ACT_LOAD: begin
			if (job_total >= JOBS) begin
				r.load_refused = 1'b1;
			end else begin
				job_arrival[job_total] = arrival;
				job_burst[job_total] = burst;
				job_left[job_total] = burst;
				job_total++;
				id_val = job_total;
				r.job_id = id_val[IDW-1:0];
			end
		end
		srtf_pkg::ACT_TICK: begin
			// pick the eligible job with least work left, then earliest arrival
			for (int k = 0; k < job_total; k++) begin
				if (job_left[k] == '0 || job_arrival[k] > sched_time)
					continue;
				if (!found || job_left[k] < job_left[best] ||
						(job_left[k] == job_left[best] &&
						 job_arrival[k] < job_arrival[best])) begin
					best = k;
					found = 1'b1;
				end
			end
			sched_time = sched_time + TW'(1);
			if (found) begin
				r.ran_job = 1'b1;
				id_val = best + 1;
				r.job_id = id_val[IDW-1:0];
				job_left[best] = job_left[best] - TW'(1);
				if (job_left[best] == '0) begin
					r.job_finished = 1'b1;
					tat = sched_time - job_arrival[best];
					r.turnaround = tat;
					r.waiting = tat - job_burst[best];
				end
			end
		end
		srtf_pkg::ACT_CLEAR: begin
			job_total = 0;
			sched_time = '0;
		end
		default: begin
		end
		endcase
		r.time_now = sched_time;
		r.all_done = table_drained();
		return r;
	endfunction

	function automatic dir_row_t plain_row(input logic [AW-1:0] action,
			input logic [IW-1:0] arrival, input logic [IW-1:0] burst);
		dir_row_t r;
		r.action = action;
		r.arrival = arrival;
		r.burst = burst;
		r.fixed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	// row whose result is typed in: nothing ran, only the flags and time matter
	function automatic dir_row_t fixed_row(input logic [AW-1:0] action,
			input logic [IW-1:0] arrival, input logic [IW-1:0] burst,
			input logic refused, input logic [OW-1:0] t_now, input logic done);
		dir_row_t r;
		r = plain_row(action, arrival, burst);
		r.fixed = 1'b1;
		r.want.load_refused = refused;
		r.want.time_now = t_now;
		r.want.all_done = done;
		return r;
	endfunction

	function automatic logic [IW-1:0] pick_arrival();
		case ($urandom_range(0, 15))
		0: return IW'($urandom);
		1: return '1;
		default: return IW'($urandom_range(0, 20));
		endcase
	endfunction

	function automatic logic [IW-1:0] pick_burst();
		case ($urandom_range(0, 15))
		0: return IW'($urandom);
		1: return '0;
		2: return '1;
		default: return IW'($urandom_range(1, 10));
		endcase
	endfunction

	// offer one command item, hold it until accepted, then record its result
	task automatic send_item(input logic [AW-1:0] action,
			input logic [IW-1:0] arrival, input logic [IW-1:0] burst,
			input bit fixed, input sched_rsp_t want);
		sched_rsp_t pred;
		cmd_ch.valid <= 1'b1;
		cmd_ch.action <= action;
		cmd_ch.arrive_at <= arrival;
		cmd_ch.work_len <= burst;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		pred = srtf_next_result(action, arrival, burst);
		if (pred.job_finished)
			jobs_finished++;
		pending_results.push_back(fixed ? want : pred);
		items_sent++;
	endtask

	// insert a random idle burst on the command side, then send
	task automatic issue(input logic [AW-1:0] action,
			input logic [IW-1:0] arrival, input logic [IW-1:0] burst);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			cmd_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		send_item(action, arrival, burst, 1'b0, '0);
	endtask

	// stop offering until every result is back, then let the block settle
	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one job set: clear, a batch of loads, ticks until drained or capped
	task automatic job_set();
		int unsigned n_jobs;
		int unsigned ticks;
		int unsigned tick_cap;
		logic [IW-1:0] late;
		issue(srtf_pkg::ACT_CLEAR, IW'($urandom), IW'($urandom));
		n_jobs = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 18) :
			$urandom_range(1, 8);
		repeat (n_jobs) issue(srtf_pkg::ACT_LOAD, pick_arrival(), pick_burst());
		tick_cap = $urandom_range(20, 120);
		ticks = 0;
		while (ticks < tick_cap && !table_drained()) begin
			case ($urandom_range(0, 19))
			0: begin
				// late arrival around the current time
				late = sched_time + TW'($urandom_range(0, 5));
				issue(srtf_pkg::ACT_LOAD, late, pick_burst());
			end
			1: issue(ACT_UNUSED, IW'($urandom), IW'($urandom));
			default: begin
				issue(srtf_pkg::ACT_TICK, IW'($urandom), IW'($urandom));
				ticks++;
			end
			endcase
		end
		repeat ($urandom_range(0, 3))
			issue(srtf_pkg::ACT_TICK, IW'($urandom), IW'($urandom));
	endtask

	task automatic cmp_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$error("%s: expected %0d, actual %0d", name, want_v, got_v);
		end
	endtask

	task automatic check_result();
		sched_rsp_t want;
		results_checked++;
		if (pending_results.size() == 0) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$error("result item with nothing pending, time_now %0d",
					rsp_ch.time_now);
		end else begin
			want = pending_results.pop_front();
			cmp_field("load_refused", 32'(want.load_refused), 32'(rsp_ch.load_refused));
			cmp_field("ran_job", 32'(want.ran_job), 32'(rsp_ch.ran_job));
			cmp_field("job_id", 32'(want.job_id), 32'(rsp_ch.job_id));
			cmp_field("job_finished", 32'(want.job_finished), 32'(rsp_ch.job_finished));
			cmp_field("turnaround", 32'(want.turnaround), 32'(rsp_ch.turnaround));
			cmp_field("waiting", 32'(want.waiting), 32'(rsp_ch.waiting));
			cmp_field("time_now", 32'(want.time_now), 32'(rsp_ch.time_now));
			cmp_field("all_done", 32'(want.all_done), 32'(rsp_ch.all_done));
		end
	endtask

	// response side: check accepted items, stall in random bursts or on request
	initial begin
		int unsigned stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				check_result();
			if (hold_req) begin
				hold_req = 1'b0;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left != 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left = $urandom_range(0, 11);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog
	initial begin
		int unsigned cycle_count;
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("timeout after %0d cycles, %0d results pending", cycle_count,
			pending_results.size());
		$display("Test completed with failures");
		$finish;
	end

	// stimulus
	initial begin
		dir_row_t    rows [$];
		int unsigned random_start;

		cmd_ch.valid = 1'b0;
		cmd_ch.action = srtf_pkg::ACT_LOAD;
		cmd_ch.arrive_at = '0;
		cmd_ch.work_len = '0;
		rsp_ch.ready = 1'b0;
		arst_n = 1'b0;
		quiet = 1'b0;
		hold_req = 1'b0;
		fail_count = 0;
		items_sent = 0;
		results_checked = 0;
		jobs_finished = 0;
		random_sets = 0;
		job_total = 0;
		sched_time = '0;
		for (int k = 0; k < JOBS; k++) begin
			job_arrival[k] = '0;
			job_burst[k] = '0;
			job_left[k] = '0;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: idle tick, unused action, clear, extremes, ties, full table
		rows.push_back(fixed_row(srtf_pkg::ACT_TICK, 16'd0, 16'd0, 1'b0, 16'd1, 1'b1));
		rows.push_back(fixed_row(ACT_UNUSED, 16'hFFFF, 16'hFFFF, 1'b0, 16'd1, 1'b1));
		rows.push_back(fixed_row(srtf_pkg::ACT_CLEAR, 16'hFFFF, 16'h0000, 1'b0, 16'd0,
			1'b1));
		rows.push_back(plain_row(srtf_pkg::ACT_LOAD, 16'd0, 16'd3));
		rows.push_back(plain_row(srtf_pkg::ACT_LOAD, 16'd0, 16'd0));
		rows.push_back(plain_row(srtf_pkg::ACT_LOAD, 16'd1, 16'd2));
		rows.push_back(plain_row(srtf_pkg::ACT_LOAD, 16'hFFFF, 16'hFFFF));
		repeat (5) rows.push_back(plain_row(srtf_pkg::ACT_TICK, 16'hFFFF, 16'hFFFF));
		rows.push_back(plain_row(srtf_pkg::ACT_LOAD, 16'd6, 16'd1));
		rows.push_back(plain_row(srtf_pkg::ACT_LOAD, 16'd6, 16'd1));
		rows.push_back(plain_row(srtf_pkg::ACT_LOAD, 16'd6, 16'd1));
		rows.push_back(plain_row(srtf_pkg::ACT_LOAD, 16'd0, 16'hFFFF));
		rows.push_back(plain_row(srtf_pkg::ACT_LOAD, 16'hFFFF, 16'd0));
		rows.push_back(plain_row(srtf_pkg::ACT_LOAD, 16'd3, 16'd7));
		rows.push_back(plain_row(srtf_pkg::ACT_LOAD, 16'd4, 16'd4));
		rows.push_back(plain_row(srtf_pkg::ACT_LOAD, 16'd0, 16'd1));
		rows.push_back(plain_row(srtf_pkg::ACT_LOAD, 16'd2, 16'd2));
		rows.push_back(plain_row(srtf_pkg::ACT_LOAD, 16'd2, 16'd2));
		rows.push_back(plain_row(srtf_pkg::ACT_LOAD, 16'd5, 16'd0));
		rows.push_back(plain_row(srtf_pkg::ACT_LOAD, 16'd1, 16'd9));
		// table full: refused, time held at 5, long jobs still open
		rows.push_back(fixed_row(srtf_pkg::ACT_LOAD, 16'd7, 16'd7, 1'b1, 16'd5, 1'b0));
		foreach (rows[i])
			send_item(rows[i].action, rows[i].arrival, rows[i].burst, rows[i].fixed,
				rows[i].want);
		wait_drained();

		// random job sets, with a long response hold and sender pauses
		random_start = items_sent;
		while (items_sent < random_start + RANDOM_ITEMS) begin
			if (items_sent - random_start >= QUIET_FROM)
				quiet = 1'b1;
			if (random_sets == 3)
				hold_req = 1'b1;
			if (random_sets == 6 || random_sets == 15)
				wait_drained();
			job_set();
			random_sets++;
		end

		quiet = 1'b1;
		wait_drained();

		$display("Covered %0d command items and %0d result items: directed table and",
			items_sent, results_checked);
		$display("%0d random job sets with %0d jobs run to completion; %0d mismatches.",
			random_sets, jobs_finished, fail_count);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
